### hdl/acs_pkg.sv
// Shared types and constants of the accumulator processor step core.
package acs_pkg;

	localparam int WORD_W = 16;
	localparam int PC_W   = 13;
	localparam int IADR_W = 12;

	localparam logic ITEM_LOAD = 1'b0;
	localparam logic ITEM_STEP = 1'b1;

	localparam logic [3:0] OP_HALT  = 4'h0;
	localparam logic [3:0] OP_IO    = 4'h1;
	localparam logic [3:0] OP_SHIFT = 4'h2;
	localparam logic [3:0] OP_LOAD  = 4'h3;
	localparam logic [3:0] OP_STORE = 4'h4;
	localparam logic [3:0] OP_ADD   = 4'h5;
	localparam logic [3:0] OP_SUB   = 4'h6;
	localparam logic [3:0] OP_AND   = 4'h7;
	localparam logic [3:0] OP_OR    = 4'h8;
	localparam logic [3:0] OP_XOR   = 4'h9;
	localparam logic [3:0] OP_NOT   = 4'hA;
	localparam logic [3:0] OP_NOP   = 4'hB;
	localparam logic [3:0] OP_JMP   = 4'hC;
	localparam logic [3:0] OP_JMPE  = 4'hD;
	localparam logic [3:0] OP_JMPL  = 4'hE;
	localparam logic [3:0] OP_BRL   = 4'hF;

	localparam logic [3:0] SUB_HEX_IN  = 4'h0;
	localparam logic [3:0] SUB_CHR_IN  = 4'h4;
	localparam logic [3:0] SUB_HEX_OUT = 4'h8;
	localparam logic [3:0] SUB_CHR_OUT = 4'hC;
	localparam logic [3:0] SUB_SHL     = 4'h0;
	localparam logic [3:0] SUB_SHR     = 4'h4;
	localparam logic [3:0] SUB_ROTL    = 4'h8;
	localparam logic [3:0] SUB_ROTR    = 4'hC;

	localparam logic [2:0] STAT_RUN    = 3'd0;
	localparam logic [2:0] STAT_HALT   = 3'd1;
	localparam logic [2:0] STAT_BADIO  = 3'd2;
	localparam logic [2:0] STAT_BADSH  = 3'd3;
	localparam logic [2:0] STAT_PCOVF  = 3'd4;

	typedef struct packed {
		logic              ov;
		logic              oc;
		logic [WORD_W-1:0] oval;
		logic              took;
	} side_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [PC_W-1:0]   pc;
		logic [WORD_W-1:0] acc;
		side_t             side;
		logic              store;
	} exec_res_t;

endpackage

### hdl/acs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module acs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/acs_alu.sv
// Instruction execution unit: decodes one instruction and computes the next machine state.
module acs_alu import acs_pkg::*; (
	input  logic [WORD_W-1:0] instr,
	input  logic [WORD_W-1:0] acc,
	input  logic [PC_W-1:0]   pc,
	input  logic [WORD_W-1:0] cv,
	input  logic [WORD_W-1:0] operand,
	output exec_res_t         res,
	output logic              need_operand
);

	logic [3:0]          op;
	logic [3:0]          sub;
	logic [3:0]          shamt;
	logic [IADR_W-1:0]   addr;
	logic [2*WORD_W-1:0] dbl_l;
	logic [2*WORD_W-1:0] dbl_r;
	logic [PC_W-1:0]     next;

	assign op    = instr[15:12];
	assign sub   = instr[11:8];
	assign shamt = instr[3:0];
	assign addr  = instr[IADR_W-1:0];
	assign dbl_l = {acc, acc} << shamt;
	assign dbl_r = {acc, acc} >> shamt;

	always_comb begin
		res          = '0;
		res.status   = STAT_RUN;
		res.acc      = acc;
		need_operand = 1'b0;
		next         = pc + PC_W'(1);
		case (op)
			OP_HALT: res.status = STAT_HALT;
			OP_IO: begin
				case (sub)
					SUB_HEX_IN: begin
						res.acc       = cv;
						res.side.took = 1'b1;
					end
					SUB_CHR_IN: begin
						res.acc       = {8'h00, cv[7:0]};
						res.side.took = 1'b1;
					end
					SUB_HEX_OUT: begin
						res.side.ov   = 1'b1;
						res.side.oval = acc;
					end
					SUB_CHR_OUT: begin
						res.side.ov   = 1'b1;
						res.side.oc   = 1'b1;
						res.side.oval = {8'h00, acc[7:0]};
					end
					default: res.status = STAT_BADIO;
				endcase
			end
			OP_SHIFT: begin
				case (sub)
					SUB_SHL:  res.acc = acc << shamt;
					SUB_SHR:  res.acc = acc >> shamt;
					SUB_ROTL: res.acc = dbl_l[2*WORD_W-1:WORD_W];
					SUB_ROTR: res.acc = dbl_r[WORD_W-1:0];
					default:  res.status = STAT_BADSH;
				endcase
			end
			OP_LOAD: begin
				need_operand = 1'b1;
				res.acc      = operand;
			end
			OP_STORE: res.store = 1'b1;
			OP_ADD: begin
				need_operand = 1'b1;
				res.acc      = acc + operand;
			end
			OP_SUB: begin
				need_operand = 1'b1;
				res.acc      = acc - operand;
			end
			OP_AND: begin
				need_operand = 1'b1;
				res.acc      = acc & operand;
			end
			OP_OR: begin
				need_operand = 1'b1;
				res.acc      = acc | operand;
			end
			OP_XOR: begin
				need_operand = 1'b1;
				res.acc      = acc ^ operand;
			end
			OP_NOT: res.acc = ~acc;
			OP_NOP: ;
			OP_JMP: next = {1'b0, addr};
			OP_JMPE: begin
				if (acc == '0) begin
					next = {1'b0, addr};
				end
			end
			OP_JMPL: begin
				if (acc[WORD_W-1]) begin
					next = {1'b0, addr};
				end
			end
			OP_BRL: begin
				res.acc = {{(WORD_W-PC_W){1'b0}}, next};
				next    = {1'b0, addr};
			end
			default: ;
		endcase
		res.pc = (res.status == STAT_RUN) ? next : pc;
	end

endmodule

### hdl/accumulator_cpu_step_core.sv
// Top level of the accumulator processor step core with its word memory.
//
// Channel  | Handshake                  | Payload
// item     | item_valid / item_ready    | opcode, load_addr, load_word, console_value
// result   | result_valid / result_ready| run_status, pc_value, acc_value, out_valid,
//          |                            | out_is_char, out_value, input_taken
//
// A load item with an address in range writes the word memory when it is accepted; a step
// fetches its instruction in FETCH and reads any memory operand in OPER: instruction fetch
// and operand read share the one read port of the word memory. After reset a clearing pass
// writes zero to all MEM_WORDS words, one per cycle, and no item is accepted during it.
// While a result waits in the output register the next item is still accepted; its own
// result then waits in the DONE state until the output register is free.
module accumulator_cpu_step_core import acs_pkg::*; #(
	parameter int MEM_WORDS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              opcode,
	input  logic [IADR_W-1:0] load_addr,
	input  logic [WORD_W-1:0] load_word,
	input  logic [WORD_W-1:0] console_value,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [2:0]        run_status,
	output logic [PC_W-1:0]   pc_value,
	output logic [WORD_W-1:0] acc_value,
	output logic              out_valid,
	output logic              out_is_char,
	output logic [WORD_W-1:0] out_value,
	output logic              input_taken
);

	localparam int AW = $clog2(MEM_WORDS);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_OPER  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_cnt_q;
	logic [WORD_W-1:0] acc_q;
	logic [PC_W-1:0]   pc_q;
	logic [2:0]        st_q;
	logic [WORD_W-1:0] cv_q;
	logic [WORD_W-1:0] instr_q;
	logic              oor_q;
	side_t             side_q;
	logic              res_valid_q;
	exec_res_t         res_q;

	logic              accept;
	logic              slot_free;
	logic              load_in_range;
	logic              out_load;
	logic              fin;
	exec_res_t         fin_res;
	exec_res_t         arch_res;
	exec_res_t         out_next;
	logic [WORD_W-1:0] alu_instr;
	logic [WORD_W-1:0] alu_operand;
	exec_res_t         alu_res;
	logic              alu_need;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	assign item_ready    = (state_q == ST_IDLE);
	assign accept        = item_valid && item_ready;
	assign slot_free     = !res_valid_q || result_ready;
	assign load_in_range = ({1'b0, load_addr} < PC_W'(MEM_WORDS));

	assign alu_instr   = (state_q == ST_OPER) ? instr_q : mem_rdata;
	assign alu_operand = oor_q ? '0 : mem_rdata;

	acs_alu u_alu (
		.instr        (alu_instr),
		.acc          (acc_q),
		.pc           (pc_q),
		.cv           (cv_q),
		.operand      (alu_operand),
		.res          (alu_res),
		.need_operand (alu_need)
	);

	always_comb begin
		arch_res        = '0;
		arch_res.status = st_q;
		arch_res.pc     = pc_q;
		arch_res.acc    = acc_q;
		fin             = 1'b0;
		fin_res         = arch_res;
		case (state_q)
			ST_FETCH: begin
				if (st_q != STAT_RUN) begin
					fin = 1'b1;
				end else if (pc_q >= PC_W'(MEM_WORDS)) begin
					fin            = 1'b1;
					fin_res.status = STAT_PCOVF;
				end else if (!alu_need) begin
					fin     = 1'b1;
					fin_res = alu_res;
				end
			end
			ST_OPER: begin
				fin     = 1'b1;
				fin_res = alu_res;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && opcode == ITEM_LOAD && load_in_range) begin
			mem_we    = 1'b1;
			mem_waddr = load_addr[AW-1:0];
			mem_wdata = load_word;
		end else if (fin && fin_res.store &&
				({1'b0, alu_instr[IADR_W-1:0]} < PC_W'(MEM_WORDS))) begin
			mem_we    = 1'b1;
			mem_waddr = alu_instr[AW-1:0];
			mem_wdata = acc_q;
		end
	end

	assign mem_raddr = (state_q == ST_FETCH) ? mem_rdata[AW-1:0] : pc_q[AW-1:0];

	acs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_load = slot_free && ((accept && opcode == ITEM_LOAD) || fin ||
		(state_q == ST_DONE));

	always_comb begin
		out_next = arch_res;
		if (state_q == ST_DONE) begin
			out_next.side = side_q;
		end else if (fin) begin
			out_next = fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			acc_q       <= '0;
			pc_q        <= '0;
			st_q        <= STAT_RUN;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (opcode == ITEM_STEP) begin
							state_q <= ST_FETCH;
						end else if (!slot_free) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_FETCH: begin
					if (fin) begin
						state_q <= slot_free ? ST_IDLE : ST_DONE;
					end else begin
						state_q <= ST_OPER;
					end
				end
				ST_OPER: state_q <= slot_free ? ST_IDLE : ST_DONE;
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin) begin
				acc_q <= fin_res.acc;
				pc_q  <= fin_res.pc;
				st_q  <= fin_res.status;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cv_q   <= console_value;
			side_q <= '0;
		end
		if (state_q == ST_FETCH) begin
			instr_q <= mem_rdata;
			oor_q   <= ({1'b0, mem_rdata[IADR_W-1:0]} >= PC_W'(MEM_WORDS));
		end
		if (fin) begin
			side_q <= fin_res.side;
		end
		if (out_load) begin
			res_q <= out_next;
		end
	end

	assign result_valid = res_valid_q;
	assign run_status   = res_q.status;
	assign pc_value     = res_q.pc;
	assign acc_value    = res_q.acc;
	assign out_valid    = res_q.side.ov;
	assign out_is_char  = res_q.side.oc;
	assign out_value    = res_q.side.oval;
	assign input_taken  = res_q.side.took;

	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != STAT_RUN) |=> (st_q == $past(st_q)))
		else $error("Machine status left a stopped state.");

	a_stopped_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != STAT_RUN && state_q == ST_FETCH) |=>
		(pc_q == $past(pc_q) && acc_q == $past(acc_q)))
		else $error("A step on a stopped machine changed pc or accumulator.");

	a_quiet_output: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.side.ov) |-> (res_q.side.oval == '0 && !res_q.side.oc))
		else $error("Console output fields set without an output instruction.");

	a_io_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.side.ov && res_q.side.took))
		else $error("One item both took input and produced output.");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (mem_we || state_q == ST_IDLE) && !res_valid_q)
		else $error("Item activity during the memory clearing pass.");

endmodule
